FILE: hdl/kr_pkg.sv
// Shared types and constants for the key remap learner.
package kr_pkg;

  localparam int CODE_W = 14;

  localparam logic [4:0] EVT_KEY   = 5'd1;
  localparam logic [1:0] VAL_PRESS = 2'd1;

  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_SYNC = 2'd1;
  localparam logic [1:0] KIND_QUIT = 2'd2;

  typedef struct packed {
    logic [4:0]        event_type;
    logic [CODE_W-1:0] key_code;
    logic [1:0]        key_value;
  } evt_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [CODE_W-1:0] out_code;
    logic [1:0]        out_value;
    logic              last;
  } res_t;

  // key event as handed from the front end to the back end
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [1:0]        value;
    logic              press;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

FILE: hdl/key_remap_learner_core.sv
// Top level of the key remap learner: front end, command queue, back end, result queue.
//
//   port group             dir  handshake      item
//   item / push / full     in   push & !full   kr_pkg::evt_t
//   result / pop / empty   out  pop & !empty   kr_pkg::res_t
//
// After reset the key table is loaded with identity values, one entry per cycle,
// while full stays high. An item is handled in the idle state of the back end; a
// learned target also passes the lookup state, and a remapped key the lookup and
// sync states (a table read, then the key and sync results pushed one per cycle). The
// back end starts an item only with the result queue empty; the two-entry command
// queue keeps input accepted meanwhile, so a stalled result port backs up into full.
module key_remap_learner_core #(
  parameter int KEY_COUNT = 16384
) (
  input  logic         clk,
  input  logic         rst,
  input  kr_pkg::evt_t item,
  input  logic         push,
  output logic         full,
  output kr_pkg::res_t result,
  output logic         empty,
  input  logic         pop
);

  import kr_pkg::*;

  cmd_t       cmd_in;
  cmd_t       cmd_out;
  logic       cmd_push;
  logic       cmd_full;
  logic       cmd_pop;
  logic       cmd_empty;
  res_t       res_item;
  logic       res_push;
  logic       res_full;
  back_stat_t stat;

  kr_front u_front (
    .item     (item),
    .push     (push),
    .full     (full),
    .cmd      (cmd_in),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .stat     (stat)
  );

  kr_fifo #(.item_t(cmd_t), .DEPTH(2)) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_item (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_item (cmd_out),
    .empty   (cmd_empty)
  );

  kr_back #(.KEY_COUNT(KEY_COUNT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_item  (res_item),
    .res_push  (res_push),
    .res_empty (empty),
    .stat      (stat)
  );

  kr_fifo #(.item_t(res_t), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_item (res_item),
    .full    (res_full),
    .pop     (pop),
    .rd_item (result),
    .empty   (empty)
  );

  // the back end only starts work with an empty result queue
  a_res_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_key_then_sync: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last) |=> (!empty && result.result_kind == KIND_SYNC))
    else $error("remapped key not followed by sync report");

  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> (empty && cmd_empty))
    else $error("activity during table initialization");

endmodule

FILE: hdl/kr_fifo.sv
// Small register queue used between the front end, back end and result port.
module kr_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/kr_front.sv
// Front end: takes input items, drops non-key events, decodes presses.
module kr_front (
  input  kr_pkg::evt_t       item,
  input  logic               push,
  output logic               full,
  output kr_pkg::cmd_t       cmd,
  output logic               cmd_push,
  input  logic               cmd_full,
  input  kr_pkg::back_stat_t stat
);

  import kr_pkg::*;

  logic accepted;

  // hold off while the table is being initialized
  assign full     = cmd_full || stat.clearing;
  assign accepted = push && !full;
  assign cmd_push = accepted && (item.event_type == EVT_KEY);

  assign cmd.code  = item.key_code;
  assign cmd.value = item.key_value;
  assign cmd.press = (item.key_value == VAL_PRESS);

endmodule

FILE: hdl/kr_back.sv
// Back end: learn/remap sequencer with the key table memory.
module kr_back #(
  parameter int KEY_COUNT = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  kr_pkg::cmd_t       cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output kr_pkg::res_t       res_item,
  output logic               res_push,
  input  logic               res_empty,
  output kr_pkg::back_stat_t stat
);

  import kr_pkg::*;

  localparam int AW = $clog2(KEY_COUNT);
  localparam logic [CODE_W:0] KEY_LIMIT = (CODE_W + 1)'(KEY_COUNT);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_SYNC} state_t;
  typedef enum logic [1:0] {PH_AWAIT, PH_LEARN, PH_REMAP, PH_HALT} phase_t;

  state_t            state;
  phase_t            phase;
  logic [AW-1:0]     clr_cnt;
  logic [CODE_W-1:0] quit_code;
  logic [CODE_W-1:0] source_code;
  logic              source_held;
  logic [CODE_W-1:0] cur_code;
  logic [1:0]        cur_value;
  logic              cur_in_range;

  logic [CODE_W-1:0] table_mem [KEY_COUNT];
  logic [CODE_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CODE_W-1:0] mem_wdata;

  logic [CODE_W-1:0] pick_code;
  logic              pick_in_range;
  logic [CODE_W-1:0] looked;
  logic              quit_hit;

  assign stat.clearing = (state == ST_CLEAR);

  always_comb begin
    // learn mode looks up the held source, remap mode the incoming code
    pick_code     = (phase == PH_LEARN) ? source_code : cmd.code;
    pick_in_range = ({1'b0, pick_code} < KEY_LIMIT);
    rd_addr       = pick_code[AW-1:0];
    // codes beyond the table translate to themselves
    looked   = cur_in_range ? rd_data : ((phase == PH_LEARN) ? source_code : cur_code);
    quit_hit = (phase == PH_LEARN || phase == PH_REMAP) && cmd.press &&
               (cmd.code == quit_code);
    cmd_pop  = (state == ST_IDLE) && !cmd_empty && res_empty;

    mem_we    = (state == ST_CLEAR) ||
                ((state == ST_LOOK) && (phase == PH_LEARN) && (looked != cur_code) &&
                 cur_in_range);
    mem_waddr = (state == ST_CLEAR) ? clr_cnt : source_code[AW-1:0];
    mem_wdata = (state == ST_CLEAR) ? CODE_W'(clr_cnt) : cur_code;

    res_push = 1'b0;
    res_item = '0;
    unique case (state)
      ST_CLEAR: ;
      ST_IDLE: begin
        if (cmd_pop && quit_hit) begin
          res_push             = 1'b1;
          res_item.result_kind = KIND_QUIT;
          res_item.last        = 1'b1;
        end
      end
      ST_LOOK: begin
        if (phase == PH_REMAP) begin
          res_push             = 1'b1;
          res_item.result_kind = KIND_KEY;
          res_item.out_code    = looked;
          res_item.out_value   = cur_value;
        end
      end
      ST_SYNC: begin
        res_push             = 1'b1;
        res_item.result_kind = KIND_SYNC;
        res_item.last        = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      phase       <= PH_AWAIT;
      clr_cnt     <= '0;
      quit_code   <= '0;
      source_code <= '0;
      source_held <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(KEY_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            cur_code     <= cmd.code;
            cur_value    <= cmd.value;
            cur_in_range <= pick_in_range;
            unique case (phase)
              PH_AWAIT: begin
                if (cmd.press) begin
                  quit_code <= cmd.code;
                  phase     <= PH_LEARN;
                end
              end
              PH_LEARN: begin
                priority if (quit_hit) begin
                  phase <= PH_HALT;
                end else if (cmd.press && !source_held) begin
                  source_code <= cmd.code;
                  source_held <= 1'b1;
                end else if (cmd.press) begin
                  state <= ST_LOOK;
                end else begin
                  // releases and autorepeats are ignored while learning
                end
              end
              PH_REMAP: begin
                if (quit_hit) begin
                  phase <= PH_HALT;
                end else begin
                  state <= ST_LOOK;
                end
              end
              PH_HALT: ;
            endcase
          end
        end
        ST_LOOK: begin
          if (phase == PH_LEARN) begin
            source_held <= 1'b0;
            // target equal to the current entry ends learning
            if (looked == cur_code) begin
              phase <= PH_REMAP;
            end
            state <= ST_IDLE;
          end else begin
            state <= ST_SYNC;
          end
        end
        ST_SYNC: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
